### rtl/tkct_pkg.sv
// shared constants and action codes of the top-k count table
package tkct_pkg;

    localparam int TOP_K   = 16;
    localparam int IDX_W   = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int OCC_W   = $clog2(TOP_K + 1);
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 31;
    localparam int LIMIT_W = 5;
    localparam int ACT_W   = 2;
    localparam int RAM_W   = KEY_W + COUNT_W;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((KEY_W + COUNT_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = KEY_W + COUNT_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EVICT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REJECT = 2'd3;

endpackage

### rtl/top_k_count_table_top.sv
// top level of the top-k count table: scan sequencer around the entry ram
// usage
//   slave stream s_*: one transfer offers a key id and its count. the block
//   takes one offer at a time and raises s_tready only when it is idle.
//   master stream m_*: one result transfer per offer, with the action in
//   m_tuser and the evicted entry and the new occupancy in m_tdata.
//   i_cfg_we / i_cfg_wdata write table_limit (0 acts as 1, above TOP_K acts
//   as TOP_K); write it only while no offer is in flight.
// scan sequence
//   after the offer transfer the block reads all TOP_K entries, one entry per
//   cycle through the single read port, compares each one as it leaves the
//   registered read pipe, then decides and writes back. the next offer is
//   taken only after the decide step, so offers never overlap in the scan.
// reset
//   i_rst_n (synchronous, active low) empties the table through the valid
//   flops, sets table_limit to 16 and drops any pending result.
// stall
//   the result sits in an output register; a new offer is still taken and
//   scanned while it waits, and the decide step holds until it is taken.
module top_k_count_table_top import tkct_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // offer stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key_id[31:0], entry_count[62:32], zero pad
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // evicted_key[31:0], evicted_count[62:32],
                                              // occupancy[67:63], zero pad
    output logic [ACT_W-1:0]       m_tuser,   // action[1:0]
    // configuration
    input  logic                   i_cfg_we,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_K - 1);

    // control state
    logic [1:0]         r_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [TOP_K-1:0]   r_valid;
    logic [OCC_W-1:0]   r_occ;
    logic               r_rd_go;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_pr_vld;
    logic [IDX_W-1:0]   r_pr_idx;
    logic               r_match_hit;
    logic               r_min_hit;
    logic               r_out_vld;

    // payload
    logic [KEY_W-1:0]   r_key;
    logic [COUNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]   r_match_idx;
    logic [IDX_W-1:0]   r_min_idx;
    logic [KEY_W-1:0]   r_min_key;
    logic [COUNT_W-1:0] r_min_cnt;
    logic [ACT_W-1:0]   r_out_act;
    logic [KEY_W-1:0]   r_out_ekey;
    logic [COUNT_W-1:0] r_out_ecnt;
    logic [OCC_W-1:0]   r_out_occ;

    // ram side
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [RAM_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [COUNT_W-1:0] rd_cnt;

    // decide step
    logic               s_acc;
    logic               fire;
    logic [OCC_W-1:0]   lim_eff;
    logic [IDX_W-1:0]   free_idx;
    logic               ins_ok;
    logic               ev_ok;
    logic               rd_hit;
    logic               rd_better;
    logic [ACT_W-1:0]   n_act;
    logic [KEY_W-1:0]   n_ekey;
    logic [COUNT_W-1:0] n_ecnt;
    logic [OCC_W-1:0]   n_occ;

    assign s_tready = (r_state == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign fire     = (r_state == ST_DECIDE) && (!r_out_vld || m_tready);

    // entry store: key in the upper bits, count in the lower bits
    tkct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TOP_K)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_key, r_cnt}),
        .i_re    (r_rd_go),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[RAM_W-1 -: KEY_W];
    assign rd_cnt = ram_rdata[COUNT_W-1:0];

    // entry coming out of the ram this cycle
    assign rd_hit    = r_valid[r_pr_idx] && (rd_key == r_key);
    assign rd_better = !r_min_hit || (rd_cnt < r_min_cnt) ||
                       ((rd_cnt == r_min_cnt) && (rd_key < r_min_key));

    // table_limit saturated to 1..TOP_K
    always_comb begin
        if (r_limit == '0) begin
            lim_eff = OCC_W'(1);
        end else if (int'(r_limit) > TOP_K) begin
            lim_eff = OCC_W'(TOP_K);
        end else begin
            lim_eff = OCC_W'(r_limit);
        end
    end

    // lowest free slot; one exists whenever occupancy is below the limit
    always_comb begin
        free_idx = '0;
        for (int i = TOP_K - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign ins_ok = (r_occ < lim_eff);
    assign ev_ok  = r_min_hit && (r_cnt > r_min_cnt);

    // priority: existing key, free slot, eviction of the minimum, reject
    always_comb begin
        n_act     = ACT_REJECT;
        n_ekey    = '0;
        n_ecnt    = '0;
        n_occ     = r_occ;
        ram_waddr = r_match_idx;
        if (r_match_hit) begin
            n_act = ACT_UPDATE;
        end else if (ins_ok) begin
            n_act     = ACT_INSERT;
            ram_waddr = free_idx;
            n_occ     = r_occ + OCC_W'(1);
        end else if (ev_ok) begin
            n_act     = ACT_EVICT;
            ram_waddr = r_min_idx;
            n_ekey    = r_min_key;
            n_ecnt    = r_min_cnt;
        end
    end

    assign ram_we = fire && (n_act != ACT_REJECT);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_rd_go     <= 1'b0;
            r_rd_idx    <= '0;
            r_pr_vld    <= 1'b0;
            r_pr_idx    <= '0;
            r_match_hit <= 1'b0;
            r_min_hit   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            // a new result replaces the one leaving in the same cycle
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_state     <= ST_SCAN;
                        r_rd_go     <= 1'b1;
                        r_rd_idx    <= '0;
                        r_match_hit <= 1'b0;
                        r_min_hit   <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // each entry is compared in the cycle after its read is issued
                    r_pr_vld <= r_rd_go;
                    r_pr_idx <= r_rd_idx;
                    if (r_rd_go) begin
                        r_rd_idx <= r_rd_idx + IDX_W'(1);
                        if (r_rd_idx == LAST_IDX) begin
                            r_rd_go <= 1'b0;
                        end
                    end
                    if (r_pr_vld) begin
                        if (!r_match_hit && rd_hit) begin
                            r_match_hit <= 1'b1;
                        end
                        if (r_valid[r_pr_idx] && rd_better) begin
                            r_min_hit <= 1'b1;
                        end
                        if (r_pr_idx == LAST_IDX) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    r_pr_vld <= 1'b0;
                    if (fire) begin
                        r_occ     <= n_occ;
                        r_state   <= ST_IDLE;
                        if (n_act == ACT_INSERT) begin
                            r_valid[free_idx] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_key <= s_tdata[KEY_W-1:0];
            r_cnt <= s_tdata[KEY_W +: COUNT_W];
        end
        if ((r_state == ST_SCAN) && r_pr_vld) begin
            if (!r_match_hit && rd_hit) begin
                r_match_idx <= r_pr_idx;
            end
            if (r_valid[r_pr_idx] && rd_better) begin
                r_min_idx <= r_pr_idx;
                r_min_key <= rd_key;
                r_min_cnt <= rd_cnt;
            end
        end
        if (fire) begin
            r_out_act  <= n_act;
            r_out_ekey <= n_ekey;
            r_out_ecnt <= n_ecnt;
            r_out_occ  <= n_occ;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out_act;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_RAW_W){1'b0}}, r_out_occ, r_out_ecnt, r_out_ekey};

endmodule

### rtl/tkct_ram.sv
// generic single-write, single-read ram with registered read data
module tkct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tkct_checker.sv
// port-level checks of the top-k count table, bound to the top level
module tkct_checker import tkct_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [ACT_W-1:0]       m_tuser
);

    logic [KEY_W-1:0]   c_ekey;
    logic [COUNT_W-1:0] c_ecnt;
    logic [OCC_W-1:0]   c_occ;

    assign c_ekey = m_tdata[KEY_W-1:0];
    assign c_ecnt = m_tdata[KEY_W +: COUNT_W];
    assign c_occ  = m_tdata[KEY_W + COUNT_W +: OCC_W];

    // only an eviction reports an evicted entry
    a_evict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser != ACT_EVICT)) |-> ((c_ekey == '0) && (c_ecnt == '0)))
        else $error("evicted fields nonzero without eviction");

    // occupancy never exceeds the table size
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (int'(c_occ) <= TOP_K))
        else $error("occupancy above table size");

    // an accepted offer occupies the scan, no back-to-back acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("offer accepted while another is in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind top_k_count_table_top tkct_checker u_tkct_checker (.*);

### bench/top_k_count_table_top_test.sv
// self-checking bench for the top-k count table: random offers against a predicted table
module top_k_count_table_top_test;
    import tkct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result transfer
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [KEY_W-1:0]   evicted_key;
        logic [COUNT_W-1:0] evicted_count;
        logic [OCC_W-1:0]   occupancy;
    } table_outcome_t;

    // holds a private copy of the table and the limit, predicts each offer and
    // checks the result transfers in order
    class table_scoreboard;
        logic [KEY_W-1:0]   slot_key   [TOP_K];
        logic [COUNT_W-1:0] slot_count [TOP_K];
        bit                 slot_used  [TOP_K];
        int unsigned        used_total;
        logic [LIMIT_W-1:0] limit_reg;
        table_outcome_t     awaited_outcomes [$];
        int unsigned        mismatches;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                slot_key[i]   = '0;
                slot_count[i] = '0;
            end
            used_total = 0;
            limit_reg  = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void write_limit(logic [LIMIT_W-1:0] value);
            limit_reg = value;
        endfunction

        // limit register clamped to 1..TOP_K
        function int unsigned kept_max();
            int unsigned lim;
            lim = limit_reg;
            if (lim < 1)
                lim = 1;
            if (lim > TOP_K)
                lim = TOP_K;
            return lim;
        endfunction

        function void note_offer(logic [KEY_W-1:0] key, logic [COUNT_W-1:0] count);
            int             hit;
            int             vacant;
            int             weakest;
            table_outcome_t outcome;
            hit     = -1;
            vacant  = -1;
            weakest = -1;
            outcome = '0;
            for (int i = 0; i < TOP_K; i++) begin
                if (!slot_used[i]) begin
                    if (vacant < 0)
                        vacant = i;
                end else begin
                    if (hit < 0 && slot_key[i] == key)
                        hit = i;
                    // smallest count, ties to the lowest key
                    if (weakest < 0 || slot_count[i] < slot_count[weakest] ||
                        (slot_count[i] == slot_count[weakest] &&
                         slot_key[i] < slot_key[weakest]))
                        weakest = i;
                end
            end
            if (hit >= 0) begin
                slot_count[hit] = count;
                outcome.action  = ACT_UPDATE;
            end else if (used_total < kept_max() && vacant >= 0) begin
                slot_key[vacant]   = key;
                slot_count[vacant] = count;
                slot_used[vacant]  = 1'b1;
                used_total++;
                outcome.action     = ACT_INSERT;
            end else if (weakest >= 0 && count > slot_count[weakest]) begin
                outcome.evicted_key   = slot_key[weakest];
                outcome.evicted_count = slot_count[weakest];
                slot_key[weakest]     = key;
                slot_count[weakest]   = count;
                outcome.action        = ACT_EVICT;
            end else begin
                outcome.action = ACT_REJECT;
            end
            outcome.occupancy = OCC_W'(used_total);
            awaited_outcomes.push_back(outcome);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic [ACT_W-1:0] user);
            table_outcome_t want;
            if (awaited_outcomes.size() == 0) begin
                $error("result transfer with no offer pending: tuser %0d tdata %h", user, data);
                mismatches++;
                return;
            end
            want = awaited_outcomes.pop_front();
            if (user !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, user);
                mismatches++;
            end
            if (data[31:0] !== want.evicted_key) begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, data[31:0]);
                mismatches++;
            end
            if (data[62:32] !== want.evicted_count) begin
                $error("evicted_count: expected %h, got %h", want.evicted_count, data[62:32]);
                mismatches++;
            end
            if (data[67:63] !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, data[67:63]);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;   // key_id[31:0], entry_count[62:32], zero pad
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // evicted_key[31:0], evicted_count[62:32],
                                                // occupancy[67:63], zero pad
    logic [ACT_W-1:0]       m_tuser;            // action[1:0]
    logic                   i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]     i_cfg_wdata = '0;

    // percentage of cycles in which each side holds back
    int unsigned offer_gap_pct  = 18;
    int unsigned result_hold_pct = 54;

    table_scoreboard sb = new();

    top_k_count_table_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= result_hold_pct);
    end

    // transfer monitor: values read here are the ones present before the edge.
    // the result is checked first, it always belongs to an older offer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_offer(s_tdata[31:0], s_tdata[62:32]);
        end
    end

    // present one offer and hold it until the transfer; called right after an edge,
    // tvalid stays high across back-to-back offers
    task automatic send_offer(logic [KEY_W-1:0] key, logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < offer_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, count, key};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // limit write, only with the block idle
    task automatic write_table_limit(logic [LIMIT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_limit(value);
        i_cfg_we    <= 1'b0;
    endtask

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [LIMIT_W-1:0] phase_limit [9];
        logic [KEY_W-1:0]   key_pool    [24];
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        int unsigned        offers_done;
        int unsigned        pick;

        // limit 2 sits below the occupancy left by the directed part, 3 below a
        // full table; 0 and 31, 17 probe the clamping at both ends
        phase_limit = '{5'd2, 5'd7, 5'd1, 5'd13, 5'd31, 5'd17, 5'd16, 5'd3, 5'd0};
        offers_done = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: single-entry table (limit 0 acts as 1)
        write_table_limit(5'd0);
        send_offer(32'h0000_0000, 31'h0000_0000);   // zero count still inserts
        send_offer(32'hFFFF_FFFF, 31'h0000_0000);   // equal count on full table: rejected
        send_offer(32'hFFFF_FFFF, 31'h7FFF_FFFF);   // beats the minimum: evicts key 0
        send_offer(32'hFFFF_FFFF, 31'h0000_0000);   // update accepted whatever the count
        send_offer(32'h0000_0001, 31'h0000_0000);   // zero count on full table: rejected
        send_offer(32'h0000_0002, 31'h0000_0001);   // evicts the all-ones key

        write_table_limit(5'd1);
        send_offer(32'h0000_0003, 31'h0000_0001);   // tie with the stored count: rejected

        // ---- directed: four entries, eviction among equal counts
        write_table_limit(5'd4);
        send_offer(32'h0000_0009, 31'd5);
        send_offer(32'h0000_0008, 31'd5);
        send_offer(32'h0000_0007, 31'd5);           // table full at limit
        send_offer(32'h0000_0006, 31'd2);           // evicts key 2 (count 1)
        send_offer(32'h0000_0006, 31'd5);           // four entries now share count 5
        send_offer(32'h0000_000A, 31'd5);           // equal to minimum: rejected
        send_offer(32'h0000_000A, 31'd6);           // tie goes to the lowest key, 6
        offers_done = 14;

        // ---- random phases, each under its own limit
        foreach (phase_limit[p]) begin
            write_table_limit(phase_limit[p]);
            foreach (key_pool[k])
                key_pool[k] = $urandom;
            for (int n = 0; n < 190; n++) begin
                // idling profile: sender light, then receiver light, then none
                if (offers_done < 580) begin
                    offer_gap_pct   = 18;
                    result_hold_pct = 54;
                end else if (offers_done < 1150) begin
                    offer_gap_pct   = 54;
                    result_hold_pct = 18;
                end else begin
                    offer_gap_pct   = 0;
                    result_hold_pct = 0;
                end
                // mostly a small key pool so updates and evictions happen,
                // some fresh keys as noise
                if ($urandom_range(99) < 12)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(23)];
                // small counts give ties and equal-count rejects
                pick = $urandom_range(99);
                if (pick < 50)
                    count = COUNT_W'($urandom_range(8));
                else if (pick < 80)
                    count = COUNT_W'($urandom_range(100000, 1));
                else
                    count = COUNT_W'($urandom);
                send_offer(key, count);
                offers_done++;
            end
        end

        // ---- wind down
        drain_results();
        repeat (25) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tkct_pkg.sv
rtl/tkct_ram.sv
rtl/top_k_count_table_top.sv
rtl/tkct_checker.sv
bench/top_k_count_table_top_test.sv
